[sv/utf8_stream_validator_macros.svh]
`ifndef UTF8_STREAM_VALIDATOR_MACROS_SVH
`define UTF8_STREAM_VALIDATOR_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define UTF8V_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define UTF8V_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/utf8v_pkg.sv]
package utf8v_pkg;

    localparam logic [7:0] ASCII_MAX   = 8'h7F;
    localparam logic [7:0] LEAD2_LO    = 8'hC2;
    localparam logic [7:0] LEAD2_HI    = 8'hDF;
    localparam logic [7:0] LEAD3_E0    = 8'hE0;
    localparam logic [7:0] LEAD3_ED    = 8'hED;
    localparam logic [7:0] LEAD3_HI    = 8'hEF;
    localparam logic [7:0] LEAD4_F0    = 8'hF0;
    localparam logic [7:0] LEAD4_F4    = 8'hF4;
    localparam logic [7:0] CONT_LO     = 8'h80;
    localparam logic [7:0] CONT_HI     = 8'hBF;
    localparam logic [7:0] CONT_E0_LO  = 8'hA0;
    localparam logic [7:0] CONT_ED_HI  = 8'h9F;
    localparam logic [7:0] CONT_F0_LO  = 8'h90;
    localparam logic [7:0] CONT_F4_HI  = 8'h8F;

    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    localparam int OUT_DATA_BITS  = 40;

    typedef enum logic [1:0] {
        CLS_SINGLE,
        CLS_LEAD,
        CLS_BAD
    } lead_class_t;

    typedef enum logic [2:0] {
        RULE_ANY,
        RULE_E0,
        RULE_ED,
        RULE_F0,
        RULE_F4
    } rule_t;

    typedef enum logic [1:0] {
        VERDICT_OK,
        VERDICT_MALFORMED,
        VERDICT_NUL
    } verdict_t;

    // cont_ok holds one bit per rule_t value: the byte fits that continuation range.
    typedef struct packed {
        lead_class_t lead_class;
        logic [1:0]  lead_count;
        rule_t       lead_rule;
        logic [4:0]  cont_ok;
        logic        is_zero;
        logic        last;
    } item_t;

endpackage

[sv/utf8v_front.sv]
module utf8v_front
    import utf8v_pkg::*;
(
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output item_t      item
);

    always_comb
    begin
        item            = '0;
        item.lead_class = CLS_BAD;
        item.lead_count = 2'd0;
        item.lead_rule  = RULE_ANY;
        if (data_byte <= ASCII_MAX)
        begin
            item.lead_class = CLS_SINGLE;
        end
        else if (data_byte inside {[LEAD2_LO:LEAD2_HI]})
        begin
            item.lead_class = CLS_LEAD;
            item.lead_count = 2'd1;
        end
        else if (data_byte inside {[LEAD3_E0:LEAD3_HI]})
        begin
            item.lead_class = CLS_LEAD;
            item.lead_count = 2'd2;
            if (data_byte == LEAD3_E0)
            begin
                item.lead_rule = RULE_E0;
            end
            else if (data_byte == LEAD3_ED)
            begin
                item.lead_rule = RULE_ED;
            end
        end
        else if (data_byte inside {[LEAD4_F0:LEAD4_F4]})
        begin
            item.lead_class = CLS_LEAD;
            item.lead_count = 2'd3;
            if (data_byte == LEAD4_F0)
            begin
                item.lead_rule = RULE_F0;
            end
            else if (data_byte == LEAD4_F4)
            begin
                item.lead_rule = RULE_F4;
            end
        end

        item.cont_ok[RULE_ANY] = data_byte inside {[CONT_LO:CONT_HI]};
        item.cont_ok[RULE_E0]  = data_byte inside {[CONT_E0_LO:CONT_HI]};
        item.cont_ok[RULE_ED]  = data_byte inside {[CONT_LO:CONT_ED_HI]};
        item.cont_ok[RULE_F0]  = data_byte inside {[CONT_F0_LO:CONT_HI]};
        item.cont_ok[RULE_F4]  = data_byte inside {[CONT_LO:CONT_F4_HI]};
        item.is_zero           = (data_byte == 8'h00);
        item.last              = last_byte;
    end

endmodule

[sv/utf8v_fifo.sv]
module utf8v_fifo
    import utf8v_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  head_valid,
    output item_t head_item
);

    item_t                     entries [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_BITS-1:0] count_reg, count_next;
    logic                      push_fire;
    logic                      pop_fire;

    assign full       = (count_reg == QUEUE_CNT_BITS'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = entries[rd_ptr_reg];
    assign push_fire  = push && !full;
    assign pop_fire   = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = push_fire ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop_fire ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        case ({push_fire, pop_fire})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            entries[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[sv/utf8v_back.sv]
`include "utf8_stream_validator_macros.svh"

module utf8v_back
    import utf8v_pkg::*;
#(
    parameter int OFFSET_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  item_t       item,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output verdict_t    verdict,
    output logic [31:0] fault_offset
);

    localparam int ExtBits = (OFFSET_BITS > 32) ? OFFSET_BITS : 32;

    logic [OFFSET_BITS-1:0] count_reg, count_next;
    logic [OFFSET_BITS-1:0] lead_reg, lead_next;
    logic [OFFSET_BITS-1:0] fault_byte_reg, fault_byte_next;
    logic [OFFSET_BITS-1:0] fault_lead_reg, fault_lead_next;
    logic [OFFSET_BITS:0]   fault_end_reg, fault_end_next;
    logic [OFFSET_BITS-1:0] zero_off_reg, zero_off_next;
    logic [1:0]             exp_reg, exp_next;
    rule_t                  rule_reg, rule_next;
    logic                   fault_reg, fault_next;
    logic                   zero_reg, zero_next;
    logic                   out_valid_reg, out_valid_next;
    verdict_t               verdict_reg, verdict_next;
    logic [31:0]            offset_reg, offset_next;
    logic                   in_range;
    logic [OFFSET_BITS:0]   p_wide;
    logic [OFFSET_BITS-1:0] off_sel;
    logic [ExtBits-1:0]     off_ext;

    assign pop          = item_valid && (!item.last || !out_valid_reg || out_ready);
    assign out_valid    = out_valid_reg;
    assign verdict      = verdict_reg;
    assign fault_offset = offset_reg;
    assign p_wide       = {1'b0, count_reg};

    always_comb
    begin
        case (rule_reg)
            RULE_ANY: in_range = item.cont_ok[RULE_ANY];
            RULE_E0:  in_range = item.cont_ok[RULE_E0];
            RULE_ED:  in_range = item.cont_ok[RULE_ED];
            RULE_F0:  in_range = item.cont_ok[RULE_F0];
            RULE_F4:  in_range = item.cont_ok[RULE_F4];
            default:  in_range = item.cont_ok[RULE_ANY];
        endcase
    end

    always_comb
    begin
        count_next      = count_reg;
        lead_next       = lead_reg;
        fault_byte_next = fault_byte_reg;
        fault_lead_next = fault_lead_reg;
        fault_end_next  = fault_end_reg;
        zero_off_next   = zero_off_reg;
        exp_next        = exp_reg;
        rule_next       = rule_reg;
        fault_next      = fault_reg;
        zero_next       = zero_reg;
        verdict_next    = verdict_reg;
        offset_next     = offset_reg;
        off_sel         = '0;
        out_valid_next  = out_valid_reg && !out_ready;

        if (pop)
        begin
            if (!fault_reg)
            begin
                if (exp_reg == 2'd0)
                begin
                    if (item.lead_class == CLS_BAD)
                    begin
                        fault_next      = 1'b1;
                        fault_byte_next = count_reg;
                        fault_lead_next = count_reg;
                        fault_end_next  = p_wide;
                    end
                    else if (item.lead_class == CLS_LEAD)
                    begin
                        exp_next  = item.lead_count;
                        rule_next = item.lead_rule;
                        lead_next = count_reg;
                    end
                end
                else if (!in_range)
                begin
                    fault_next      = 1'b1;
                    fault_byte_next = count_reg;
                    fault_lead_next = lead_reg;
                    fault_end_next  = p_wide + (OFFSET_BITS + 1)'(exp_reg) - 1'b1;
                end
                else
                begin
                    exp_next  = exp_reg - 1'b1;
                    rule_next = RULE_ANY;
                end
            end

            if (item.is_zero && !zero_reg)
            begin
                zero_next     = 1'b1;
                zero_off_next = count_reg;
            end

            if (!item.last)
            begin
                if (count_reg != '1)
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            else
            begin
                if (fault_next)
                begin
                    verdict_next = VERDICT_MALFORMED;
                    off_sel      = (fault_end_next > p_wide) ? fault_lead_next
                                                             : fault_byte_next;
                end
                else if (exp_next != 2'd0)
                begin
                    verdict_next = VERDICT_MALFORMED;
                    off_sel      = lead_next;
                end
                else if (zero_next)
                begin
                    verdict_next = VERDICT_NUL;
                    off_sel      = zero_off_next;
                end
                else
                begin
                    verdict_next = VERDICT_OK;
                end
                out_valid_next  = 1'b1;
                count_next      = '0;
                lead_next       = '0;
                fault_byte_next = '0;
                fault_lead_next = '0;
                fault_end_next  = '0;
                zero_off_next   = '0;
                exp_next        = 2'd0;
                rule_next       = RULE_ANY;
                fault_next      = 1'b0;
                zero_next       = 1'b0;
            end
        end

        off_ext = ExtBits'(off_sel);
        if (pop && item.last)
        begin
            offset_next = off_ext[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            lead_reg       <= '0;
            fault_byte_reg <= '0;
            fault_lead_reg <= '0;
            fault_end_reg  <= '0;
            zero_off_reg   <= '0;
            exp_reg        <= 2'd0;
            rule_reg       <= RULE_ANY;
            fault_reg      <= 1'b0;
            zero_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            lead_reg       <= lead_next;
            fault_byte_reg <= fault_byte_next;
            fault_lead_reg <= fault_lead_next;
            fault_end_reg  <= fault_end_next;
            zero_off_reg   <= zero_off_next;
            exp_reg        <= exp_next;
            rule_reg       <= rule_next;
            fault_reg      <= fault_next;
            zero_reg       <= zero_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        verdict_reg <= verdict_next;
        offset_reg  <= offset_next;
    end

    // A restricted second-byte range is only pending right after a three- or four-byte lead.
    `UTF8V_ASSERT_NOW(a_rule_needs_open_seq, rule_reg != RULE_ANY, exp_reg >= 2'd2, "restricted rule without open sequence")
    // The first fault sticks until the stream ends.
    `UTF8V_ASSERT_NEXT(a_fault_sticky, fault_reg && !(pop && item.last), fault_reg, "fault flag dropped inside a stream")
    // The end of a stream returns the offset counter to zero.
    `UTF8V_ASSERT_NEXT(a_count_restart, pop && item.last, count_reg == '0 && !fault_reg && !zero_reg, "stream state not cleared at end")

endmodule

[sv/utf8_stream_validator.sv]
// Checks a byte stream for well-formed UTF-8 (strict lead and second-byte ranges) and for
// zero bytes, one byte per s_axis transaction, with s_axis_tlast marking the final byte of
// a stream. On that byte one m_axis transaction carries the verdict (well formed, malformed,
// or contains a zero byte, malformed winning) and the offset of the first fault; a sequence
// cut off by the stream end reports its lead offset. The block takes one byte per clock
// cycle while the queue has room; a last byte waits in the queue while a verdict is held
// on m_axis_tready, and m_axis_tvalid is registered in the back stage. A four-entry queue
// between byte classifier and state update keeps input flowing while a verdict waits.
// Offsets count up to 2**OFFSET_BITS-1 and then saturate; only their low 32 bits are reported.
module utf8_stream_validator
    import utf8v_pkg::*;
#(
    parameter int OFFSET_BITS = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [7:0]               s_axis_tdata,  // data_byte[7:0]
    input  logic                     s_axis_tlast,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [OUT_DATA_BITS-1:0] m_axis_tdata   // verdict[1:0], fault_offset[33:2], zeros
);

    item_t       front_item;
    item_t       head_item;
    logic        queue_full;
    logic        head_valid;
    logic        pop;
    verdict_t    verdict;
    logic [31:0] fault_offset;

    assign s_axis_tready = !queue_full;
    assign m_axis_tdata  = {(OUT_DATA_BITS - 34)'(0), fault_offset, verdict};

    utf8v_front u_front (
        .data_byte (s_axis_tdata),
        .last_byte (s_axis_tlast),
        .item      (front_item)
    );

    utf8v_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (s_axis_tvalid),
        .push_item  (front_item),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    utf8v_back #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (head_valid),
        .item         (head_item),
        .pop          (pop),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .verdict      (verdict),
        .fault_offset (fault_offset)
    );

endmodule
